/* hdl/rme_pkg.sv */
package rme_pkg;

   // Operand width of the modulus, exponents, messages and results.
   localparam int MOD_BITS = 31;
   localparam int CNT_BITS = $clog2(MOD_BITS);

   typedef logic [MOD_BITS-1:0] word_type;
   typedef logic [MOD_BITS:0]   wide_type;
   typedef logic [CNT_BITS-1:0] count_type;
   typedef logic [1:0]          csr_index_type;

   localparam count_type LAST_IDX = count_type'(MOD_BITS - 1);

   // Configuration register indexes.
   localparam csr_index_type CSR_MODULUS  = 2'd0;
   localparam csr_index_type CSR_PUB_EXP  = 2'd1;
   localparam csr_index_type CSR_PRIV_EXP = 2'd2;

   // Operand selection of one modular multiplication.
   typedef enum logic [1:0] {
      MUL_REDUCE = 2'd0,   // one * base, reduces the base mod n
      MUL_SQUARE = 2'd1,   // acc * acc
      MUL_TIMES  = 2'd2    // base * acc
   } mul_mode_type;

   typedef struct packed {
      logic         load;       // latch base, exponent and acc = 1 mod n
      logic         mul_load;   // set up multiplier operands for mode
      logic         mul_step;   // one shift-and-add step
      logic         store;      // write product back by mode
      logic         exp_shift;  // advance to next exponent bit
      logic         finish;     // write result and held ciphertext
      mul_mode_type mode;
   } cmd_type;

   typedef struct packed {
      logic exp_bit;   // current exponent bit, most significant first
   } status_type;

endpackage

/* hdl/rme_chan_if.sv */
interface rme_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic [rme_pkg::MOD_BITS-1:0]      message;

   modport source (output valid, output func, output message, input ready);
   modport sink   (input valid, input func, input message, output ready);
endinterface

interface rme_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rme_pkg::MOD_BITS-1:0]      result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

/* hdl/rme_dpath.sv */
module rme_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  rme_pkg::cmd_type       cmd,
   output rme_pkg::status_type    status,
   input  logic                   csr_write_en,
   input  rme_pkg::csr_index_type csr_index,
   input  rme_pkg::word_type      csr_wdata,
   input  logic                   req_func,
   input  rme_pkg::word_type      req_message,
   output rme_pkg::word_type      result
);
   import rme_pkg::*;

   word_type modulus_ff,  modulus_in;
   word_type pub_exp_ff,  pub_exp_in;
   word_type priv_exp_ff, priv_exp_in;
   word_type held_ff,     held_in;
   word_type base_ff,     base_in;
   word_type exp_ff,      exp_in;
   word_type acc_ff,      acc_in;
   word_type mul_x_ff,    mul_x_in;
   word_type mul_y_ff,    mul_y_in;
   word_type mul_r_ff,    mul_r_in;
   word_type result_ff,   result_in;

   word_type one_mod;
   word_type final_val;
   wide_type dbl, dbl_red, sum, sum_red;
   word_type dbl_mod;

   assign one_mod   = (modulus_ff == word_type'(1)) ? '0 : word_type'(1);
   assign final_val = (modulus_ff == '0) ? '0 : acc_ff;

   // One shift-and-add step: r = 2r mod n, then r = r + x mod n on a set y bit.
   assign dbl     = {mul_r_ff, 1'b0};
   assign dbl_red = (dbl >= {1'b0, modulus_ff}) ? dbl - {1'b0, modulus_ff} : dbl;
   assign dbl_mod = dbl_red[MOD_BITS-1:0];
   assign sum     = {1'b0, dbl_mod} + {1'b0, mul_x_ff};
   assign sum_red = (sum >= {1'b0, modulus_ff}) ? sum - {1'b0, modulus_ff} : sum;

   always_comb begin
      modulus_in  = modulus_ff;
      pub_exp_in  = pub_exp_ff;
      priv_exp_in = priv_exp_ff;
      held_in     = held_ff;
      base_in     = base_ff;
      exp_in      = exp_ff;
      acc_in      = acc_ff;
      mul_x_in    = mul_x_ff;
      mul_y_in    = mul_y_ff;
      mul_r_in    = mul_r_ff;
      result_in   = result_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MODULUS:  modulus_in  = csr_wdata;
            CSR_PUB_EXP:  pub_exp_in  = csr_wdata;
            CSR_PRIV_EXP: priv_exp_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         base_in = req_func ? held_ff : req_message;
         exp_in  = req_func ? priv_exp_ff : pub_exp_ff;
         acc_in  = one_mod;
      end

      if (cmd.mul_load) begin
         mul_r_in = '0;
         case (cmd.mode)
            MUL_REDUCE: begin
               mul_x_in = one_mod;
               mul_y_in = base_ff;
            end
            MUL_SQUARE: begin
               mul_x_in = acc_ff;
               mul_y_in = acc_ff;
            end
            default: begin
               mul_x_in = base_ff;
               mul_y_in = acc_ff;
            end
         endcase
      end

      if (cmd.mul_step) begin
         mul_r_in = mul_y_ff[MOD_BITS-1] ? sum_red[MOD_BITS-1:0] : dbl_mod;
         mul_y_in = {mul_y_ff[MOD_BITS-2:0], 1'b0};
      end

      if (cmd.store) begin
         if (cmd.mode == MUL_REDUCE) begin
            base_in = mul_r_ff;
         end else begin
            acc_in = mul_r_ff;
         end
      end

      if (cmd.exp_shift) begin
         exp_in = {exp_ff[MOD_BITS-2:0], 1'b0};
      end

      if (cmd.finish) begin
         result_in = final_val;
         held_in   = final_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= word_type'(1);
         pub_exp_ff  <= '0;
         priv_exp_ff <= '0;
         held_ff     <= '0;
      end else begin
         modulus_ff  <= modulus_in;
         pub_exp_ff  <= pub_exp_in;
         priv_exp_ff <= priv_exp_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      acc_ff    <= acc_in;
      mul_x_ff  <= mul_x_in;
      mul_y_ff  <= mul_y_in;
      mul_r_ff  <= mul_r_in;
      result_ff <= result_in;
   end

   assign status.exp_bit = exp_ff[MOD_BITS-1];
   assign result         = result_ff;

endmodule

/* hdl/rme_ctrl.sv */
module rme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rme_pkg::status_type status,
   output rme_pkg::cmd_type    cmd
);
   import rme_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MLOAD = 5'b00010,
      S_MSTEP = 5'b00100,
      S_STORE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type    state_ff,    state_in;
   mul_mode_type mode_ff,     mode_in;
   count_type    step_cnt_ff, step_cnt_in;
   count_type    bit_cnt_ff,  bit_cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      step_cnt_in  = step_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      advance      = 1'b0;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mode     = mode_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               mode_in  = MUL_REDUCE;
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
            step_cnt_in  = LAST_IDX;
            state_in     = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.mul_step = 1'b1;
            if (step_cnt_ff == '0) begin
               state_in = S_STORE;
            end else begin
               step_cnt_in = step_cnt_ff - count_type'(1);
            end
         end
         S_STORE: begin
            cmd.store = 1'b1;
            case (mode_ff)
               MUL_REDUCE: begin
                  bit_cnt_in = LAST_IDX;
                  mode_in    = MUL_SQUARE;
                  state_in   = S_MLOAD;
               end
               MUL_SQUARE: begin
                  if (status.exp_bit) begin
                     mode_in  = MUL_TIMES;
                     state_in = S_MLOAD;
                  end else begin
                     advance = 1'b1;
                  end
               end
               default: advance = 1'b1;
            endcase
            if (advance) begin
               if (bit_cnt_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  bit_cnt_in    = bit_cnt_ff - count_type'(1);
                  cmd.exp_shift = 1'b1;
                  mode_in       = MUL_SQUARE;
                  state_in      = S_MLOAD;
               end
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      step_cnt_ff <= step_cnt_in;
      bit_cnt_ff  <= bit_cnt_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/rsa_modexp_encrypt_decrypt.sv */
// Textbook RSA modular exponentiation, left-to-right square-and-multiply.
// Program the modulus n (index 0), public exponent e (index 1) and private
// exponent d (index 2) through the csr_ write port while the block is idle.
// A request transaction with func = 0 returns message^e mod n; with func = 1
// it returns held^d mod n, where held is the result of the previous
// transaction (zero after reset). Every result is also kept as the new held
// ciphertext. An exponent of zero gives 1 mod n, and a modulus of zero gives
// 0. The block works on one transaction at a time. Each modular product is
// formed by a single shift-and-add multiplier, one operand bit per cycle,
// preceded by operand setup and followed by write-back. A transaction
// runs one product to reduce the base, one squaring per exponent bit (31)
// and one extra product per set exponent bit. A finished result waits in
// an output register; a new request is accepted as soon as the result is
// written there, even before it is taken.
module rsa_modexp_encrypt_decrypt (
   input  logic                   clock,
   input  logic                   reset,
   rme_req_if.sink                req_chan,
   rme_rsp_if.source              rsp_chan,
   input  logic                   csr_write_en,
   input  rme_pkg::csr_index_type csr_index,
   input  rme_pkg::word_type      csr_wdata
);
   import rme_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: walks the reduce / square / multiply schedule.
   rme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: config registers, held ciphertext and the modular multiplier.
   rme_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_func     (req_chan.func),
      .req_message  (req_chan.message),
      .result       (rsp_chan.result)
   );

endmodule

/* hdl/rme_checker.sv */
module rme_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [rme_pkg::MOD_BITS-1:0] rsp_result
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result))
      else $error("response dropped or changed while stalled");

   // Only one transaction at work: no new request right after acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A response never appears the cycle after a request is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response too early after request");

   // The block is idle again when a new response shows up.
   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response raised while still busy");

endmodule

bind rsa_modexp_encrypt_decrypt rme_checker u_rme_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_result (rsp_chan.result)
);
